// ===== rtl/core/sdce_pkg.sv =====
// Shared types and constants for the serial debug command engine.
`default_nettype none

package sdce_pkg;

    // Input transaction opcodes
    localparam logic [1:0] OP_STOP      = 2'd0;
    localparam logic [1:0] OP_HOST_BYTE = 2'd1;
    localparam logic [1:0] OP_READ_DATA = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_HOST   = 2'd0;
    localparam logic [1:0] KIND_RD     = 2'd1;
    localparam logic [1:0] KIND_WR     = 2'd2;
    localparam logic [1:0] KIND_RESUME = 2'd3;

    // Engine phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_HDR   = 3'd2;
    localparam logic [2:0] PH_READ  = 3'd3;
    localparam logic [2:0] PH_WRITE = 3'd4;

    // Protocol characters
    localparam logic [7:0] CH_STOP   = 8'h58; // 'X'
    localparam logic [7:0] CH_OK     = 8'h6B; // 'k'
    localparam logic [7:0] CH_MEM_WR = 8'h4D; // 'M'
    localparam logic [7:0] CH_MEM_RD = 8'h6D; // 'm'
    localparam logic [7:0] CH_REG_RD = 8'h72; // 'r'
    localparam logic [7:0] CH_REG_WR = 8'h52; // 'R'
    localparam logic [7:0] CH_CONT   = 8'h63; // 'c'

    localparam logic [2:0] MEM_HDR_LEN = 3'd6;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] mem_address;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  current_command;
        logic [2:0]  header_count;
        logic [15:0] remaining_count;
        logic [31:0] next_address;
    } eng_state_t;

    // Results produced by one input transaction
    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
    } step_res_t;

    function automatic out_item_t mk_res(logic [1:0] kind, logic [7:0] data,
                                         logic [31:0] addr);
        out_item_t r;
        r.kind        = kind;
        r.data_byte   = data;
        r.mem_address = addr;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdce_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none

interface sdce_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdce_step.sv =====
// Next-state and result logic for one input transaction.
`default_nettype none

module sdce_step (
    input  wire sdce_pkg::eng_state_t cur,
    input  wire sdce_pkg::in_item_t   item,
    input  wire logic [31:0]          frame_base,
    output sdce_pkg::eng_state_t      nxt,
    output sdce_pkg::step_res_t       res
);
    import sdce_pkg::*;

    logic        is_mem;
    logic        is_read;
    logic        is_known;
    logic [2:0]  hdr_inc;
    logic [15:0] rem_dec;
    logic [31:0] addr_inc;
    logic [31:0] reg_addr;
    logic [7:0]  b;

    assign b        = item.byte_value;
    assign is_mem   = (cur.current_command == CH_MEM_RD) || (cur.current_command == CH_MEM_WR);
    assign is_read  = (cur.current_command == CH_MEM_RD) || (cur.current_command == CH_REG_RD);
    assign is_known = (b == CH_MEM_RD) || (b == CH_MEM_WR) || (b == CH_REG_RD) ||
                      (b == CH_REG_WR);
    assign hdr_inc  = cur.header_count + 3'd1;
    assign rem_dec  = cur.remaining_count - 16'd1;
    assign addr_inc = cur.next_address + 32'd1;
    assign reg_addr = frame_base + {22'd0, b, 2'b00};

    always_comb
    begin
        logic hdr_done;
        out_item_t r0;
        out_item_t r1;
        logic [1:0] n;

        nxt      = cur;
        r0       = '0;
        r1       = '0;
        n        = 2'd0;
        hdr_done = 1'b0;

        unique case (item.opcode)
            OP_STOP:
            begin
                r0  = mk_res(KIND_HOST, CH_STOP, 32'd0);
                n   = 2'd1;
                nxt = '0;
                nxt.phase = PH_CMD;
            end
            OP_HOST_BYTE:
            begin
                unique case (cur.phase)
                    PH_CMD:
                    begin
                        nxt.current_command = b;
                        if (is_known)
                        begin
                            nxt.header_count    = 3'd0;
                            nxt.remaining_count = 16'd0;
                            nxt.next_address    = 32'd0;
                            nxt.phase           = PH_HDR;
                        end
                        else if (b == CH_CONT)
                        begin
                            r0        = mk_res(KIND_HOST, CH_OK, 32'd0);
                            r1        = mk_res(KIND_RESUME, 8'd0, 32'd0);
                            n         = 2'd2;
                            nxt.phase = PH_IDLE;
                        end
                        else
                        begin
                            r0 = mk_res(KIND_HOST, CH_OK, 32'd0);
                            n  = 2'd1;
                        end
                    end
                    PH_HDR:
                    begin
                        if (is_mem)
                        begin
                            // length bytes first, then address, both big-endian
                            if (cur.header_count < 3'd2)
                                nxt.remaining_count = {cur.remaining_count[7:0], b};
                            else
                                nxt.next_address = {cur.next_address[23:0], b};
                            nxt.header_count = hdr_inc;
                            hdr_done         = (hdr_inc >= MEM_HDR_LEN);
                        end
                        else
                        begin
                            nxt.next_address    = reg_addr;
                            nxt.remaining_count = 16'd4;
                            nxt.header_count    = 3'd1;
                            hdr_done            = 1'b1;
                        end
                        if (hdr_done)
                        begin
                            if (is_read)
                            begin
                                n = 2'd1;
                                if (nxt.remaining_count == 16'd0)
                                begin
                                    r0        = mk_res(KIND_HOST, CH_OK, 32'd0);
                                    nxt.phase = PH_CMD;
                                end
                                else
                                begin
                                    r0        = mk_res(KIND_RD, 8'd0, nxt.next_address);
                                    nxt.phase = PH_READ;
                                end
                            end
                            else
                            begin
                                r0 = mk_res(KIND_HOST, CH_MEM_WR, 32'd0);
                                if (nxt.remaining_count == 16'd0)
                                begin
                                    r1        = mk_res(KIND_HOST, CH_OK, 32'd0);
                                    n         = 2'd2;
                                    nxt.phase = PH_CMD;
                                end
                                else
                                begin
                                    n         = 2'd1;
                                    nxt.phase = PH_WRITE;
                                end
                            end
                        end
                    end
                    PH_WRITE:
                    begin
                        r0                  = mk_res(KIND_WR, b, cur.next_address);
                        nxt.next_address    = addr_inc;
                        nxt.remaining_count = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            r1        = mk_res(KIND_HOST, CH_OK, 32'd0);
                            n         = 2'd2;
                            nxt.phase = PH_CMD;
                        end
                        else
                        begin
                            n = 2'd1;
                        end
                    end
                    default:
                    begin
                        n = 2'd0;
                    end
                endcase
            end
            OP_READ_DATA:
            begin
                if (cur.phase == PH_READ)
                begin
                    r0                  = mk_res(KIND_HOST, b, 32'd0);
                    n                   = 2'd2;
                    nxt.next_address    = addr_inc;
                    nxt.remaining_count = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        r1        = mk_res(KIND_HOST, CH_OK, 32'd0);
                        nxt.phase = PH_CMD;
                    end
                    else
                    begin
                        r1 = mk_res(KIND_RD, 8'd0, addr_inc);
                    end
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        r0.last   = (n == 2'd1);
        r1.last   = (n == 2'd2);
        res.count = n;
        res.r0    = r0;
        res.r1    = r1;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdce_out_stage.sv =====
// Result register plus one hold slot for the second result of a transaction.
`default_nettype none

module sdce_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire sdce_pkg::step_res_t res_in,
    output logic                     can_take,
    sdce_chan_if.source              res
);
    import sdce_pkg::*;

    out_item_t out_reg;
    out_item_t out_next;
    out_item_t hold_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      hold_valid_reg;
    logic      hold_valid_next;
    logic      pop;

    assign pop      = out_valid_reg && res.ready;
    assign can_take = !hold_valid_reg && (!out_valid_reg || res.ready);

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg)
        begin
            if (pop)
            begin
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end
        end
        else if (fire && res_in.count != 2'd0)
        begin
            out_next        = res_in.r0;
            out_valid_next  = 1'b1;
            hold_valid_next = (res_in.count == 2'd2);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (fire && !hold_valid_reg)
            hold_reg <= res_in.r1;
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

`ifndef ASSERT_OFF
    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold slot full while result register empty");

    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_in.count == 2'd2) |=> hold_valid_reg)
        else $error("second result of a pair was not held");

    a_hold_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> hold_reg.last)
        else $error("held result is not the final one of its transaction");

    a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> can_take)
        else $error("transaction processed without output space");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/serial_debug_command_engine.sv =====
// Top level of the serial debug command engine.
//
//  channel | dir | transaction payload
//  --------+-----+--------------------------------------------------
//  cmd     | in  | opcode, byte_value (stop / host byte / read data)
//  res     | out | kind, data_byte, mem_address, last
//  cfg_*   | in  | frame_base write, no handshake
//
// An accepted transaction waits in the input register until the output stage
// can take it; the step logic then updates the engine state and loads the
// result register. One transaction per cycle while res is ready and each
// yields at most one result; after a two-result one the hold slot drains first.
// Stalls on res back up into cmd.ready; reset clears all control state.
`default_nettype none

module serial_debug_command_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    sdce_chan_if.sink        cmd,
    sdce_chan_if.source      res
);
    import sdce_pkg::*;

    in_item_t   in_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    eng_state_t state_reg;
    eng_state_t state_next;
    logic [31:0] frame_base_reg;
    step_res_t  step_res;
    logic       can_take;
    logic       fire;
    logic       accept;

    assign fire      = in_valid_reg && can_take;
    assign cmd.ready = !in_valid_reg || fire;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    sdce_step u_step (
        .cur        (state_reg),
        .item       (in_reg),
        .frame_base (frame_base_reg),
        .nxt        (state_next),
        .res        (step_res)
    );

    sdce_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .res_in   (step_res),
        .can_take (can_take),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            state_reg      <= '0;
            frame_base_reg <= 32'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
                state_reg <= state_next;
            if (cfg_wr_en)
                frame_base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= cmd.payload;
    end

`ifndef ASSERT_OFF
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_WRITE)
        else $error("phase outside defined codes");

    a_stop_enters_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_reg.opcode == OP_STOP) |=> state_reg.phase == PH_CMD)
        else $error("stop event did not enter command mode");

    a_hdr_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_HDR |-> state_reg.header_count < MEM_HDR_LEN)
        else $error("header count ran past the header length");
`endif

endmodule

`default_nettype wire
